/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising edge, disabled while reset is asserted.
`define ASSERT_CLK(lbl, ck, rstn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// Assertion that is also checked while reset is asserted.
`define ASSERT_ALWAYS(lbl, ck, prop, msg) \
    lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

/* hw/rtl/pol_pkg.sv */
// ----------------------------------------------------------------------------
// pol_pkg
// Types, codes and sizes for the positional ordered list core.
// ----------------------------------------------------------------------------
package pol_pkg;

    localparam int CAPACITY = 32;

    localparam int ACT_W = 2;
    localparam int POS_W = 6;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int LEN_W = 6;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam int IN_W   = ACT_W + POS_W + VAL_W;
    localparam int OUT_W  = ST_W + VAL_W + LEN_W;
    localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_READ   = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        logic load;
        logic exec;
    } dp_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
    } dp_stat_t;

endpackage

/* hw/rtl/pol_ctrl.sv */
// ----------------------------------------------------------------------------
// pol_ctrl
// Request sequencer: accepts one beat, runs it through the datapath once
// the output register is free, and tracks the output valid.
// ----------------------------------------------------------------------------
module pol_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output pol_pkg::dp_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.load       = 1'b0;
        cmd.exec       = 1'b0;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hw/rtl/pol_dpath.sv */
// ----------------------------------------------------------------------------
// pol_dpath
// Row of entry cells with per-cell shift, request register, length counter
// and result register.
// ----------------------------------------------------------------------------
module pol_dpath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  pol_pkg::dp_cmd_t            cmd,
    input  logic [pol_pkg::ACT_W-1:0]   action,
    input  logic [pol_pkg::POS_W-1:0]   position,
    input  logic signed [pol_pkg::VAL_W-1:0] value_in,
    output logic [pol_pkg::ST_W-1:0]    status,
    output logic signed [pol_pkg::VAL_W-1:0] value_out,
    output logic [pol_pkg::LEN_W-1:0]   length,
    output pol_pkg::dp_stat_t           stat
);

    logic [pol_pkg::ACT_W-1:0] req_action_reg;
    logic [pol_pkg::POS_W-1:0] req_pos_reg;
    logic [pol_pkg::VAL_W-1:0] req_val_reg;

    logic [pol_pkg::VAL_W-1:0] cells_reg  [pol_pkg::CAPACITY];
    logic [pol_pkg::VAL_W-1:0] cells_next [pol_pkg::CAPACITY];

    logic [pol_pkg::CNT_W-1:0] count_reg, count_next;

    logic [pol_pkg::ST_W-1:0]  out_status_reg;
    logic [pol_pkg::VAL_W-1:0] out_value_reg;
    logic [pol_pkg::LEN_W-1:0] out_length_reg;

    logic [pol_pkg::CMP_W-1:0] pos_x, cnt_x, p_x;
    logic                      pos_ok_rd, pos_ok_ins, is_full;
    logic                      do_ins, do_del;
    logic [pol_pkg::VAL_W-1:0] rd_data, res_value;
    pol_pkg::status_t          res_status;

    assign pos_x = pol_pkg::CMP_W'(req_pos_reg);
    assign cnt_x = pol_pkg::CMP_W'(count_reg);
    assign p_x   = pos_x - pol_pkg::CMP_W'(1);

    assign pos_ok_rd  = (pos_x != '0) && (pos_x <= cnt_x);
    assign pos_ok_ins = (pos_x != '0) && (pos_x <= cnt_x + pol_pkg::CMP_W'(1));
    assign is_full    = (cnt_x >= pol_pkg::CMP_W'(pol_pkg::CAPACITY));

    assign rd_data = cells_reg[p_x[pol_pkg::IDX_W-1:0]];

    always_comb
    begin
        res_status = pol_pkg::ST_OK;
        res_value  = '0;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        count_next = count_reg;
        case (pol_pkg::action_t'(req_action_reg))
            pol_pkg::ACT_INSERT:
            begin
                if (!pos_ok_ins)
                begin
                    res_status = pol_pkg::ST_BAD_POS;
                end
                else if (is_full)
                begin
                    res_status = pol_pkg::ST_FULL;
                end
                else
                begin
                    do_ins     = 1'b1;
                    count_next = count_reg + pol_pkg::CNT_W'(1);
                end
            end
            pol_pkg::ACT_READ:
            begin
                if (!pos_ok_rd)
                begin
                    res_status = pol_pkg::ST_BAD_POS;
                end
                else
                begin
                    res_value = rd_data;
                end
            end
            pol_pkg::ACT_DELETE:
            begin
                if (!pos_ok_rd)
                begin
                    res_status = pol_pkg::ST_BAD_POS;
                end
                else
                begin
                    res_value  = rd_data;
                    do_del     = 1'b1;
                    count_next = count_reg - pol_pkg::CNT_W'(1);
                end
            end
            pol_pkg::ACT_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                res_status = pol_pkg::ST_OK;
            end
        endcase
    end

    // each cell at or past the target position moves one place
    always_comb
    begin
        for (int i = 0; i < pol_pkg::CAPACITY; i++)
        begin
            cells_next[i] = cells_reg[i];
            if (pol_pkg::CMP_W'(i) >= p_x)
            begin
                if (do_ins)
                begin
                    if (pol_pkg::CMP_W'(i) == p_x)
                    begin
                        cells_next[i] = req_val_reg;
                    end
                    else if (i > 0)
                    begin
                        cells_next[i] = cells_reg[(i > 0) ? i - 1 : 0];
                    end
                end
                else if (do_del && (i < pol_pkg::CAPACITY - 1))
                begin
                    cells_next[i] = cells_reg[(i < pol_pkg::CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_action_reg <= action;
            req_pos_reg    <= position;
            req_val_reg    <= value_in;
        end
        if (cmd.exec)
        begin
            for (int i = 0; i < pol_pkg::CAPACITY; i++)
            begin
                cells_reg[i] <= cells_next[i];
            end
            out_status_reg <= res_status;
            out_value_reg  <= res_value;
            out_length_reg <= pol_pkg::LEN_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    assign status     = out_status_reg;
    assign value_out  = out_value_reg;
    assign length     = out_length_reg;
    assign stat.count = count_reg;

endmodule

/* hw/rtl/positional_ordered_list_core.sv */
// ----------------------------------------------------------------------------
// positional_ordered_list_core
// Bounded list of signed 32-bit values addressed by 1-based position:
// insert, read, delete and clear, one result beat per request beat.
// ----------------------------------------------------------------------------
//  channel | dir | fields (tdata, low bit first)
//  s_axis  | in  | action[1:0], position[7:2], value_in[39:8]
//  m_axis  | out | status[1:0], value_out[33:2], length[39:34]
//
//  A request beat is captured in S_IDLE; S_EXEC then shifts the cell
//  row and loads the result register. The next beat is taken while a result
//  waits; execution stalls only while the result register is still full.
//  Reset empties the list; entry contents need no clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_ordered_list_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [pol_pkg::IN_TW-1:0]   s_tdata,  // action, position, value_in
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [pol_pkg::OUT_TW-1:0]  m_tdata   // status, value_out, length
);

    pol_pkg::dp_cmd_t  cmd;
    pol_pkg::dp_stat_t stat;

    logic [pol_pkg::ST_W-1:0]  status;
    logic [pol_pkg::VAL_W-1:0] value_out;
    logic [pol_pkg::LEN_W-1:0] length;

    pol_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    pol_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .action    (s_tdata[pol_pkg::ACT_W-1:0]),
        .position  (s_tdata[pol_pkg::ACT_W +: pol_pkg::POS_W]),
        .value_in  (s_tdata[pol_pkg::ACT_W + pol_pkg::POS_W +: pol_pkg::VAL_W]),
        .status    (status),
        .value_out (value_out),
        .length    (length),
        .stat      (stat)
    );

    assign m_tdata = pol_pkg::OUT_TW'({length, value_out, status});

    `ASSERT_CLK(a_count_bound, clk, rst_n,
        stat.count <= pol_pkg::CNT_W'(pol_pkg::CAPACITY), "list length over capacity")
    `ASSERT_CLK(a_one_in_flight, clk, rst_n,
        (s_tvalid && s_tready) |=> !s_tready, "second beat taken while one in flight")
    `ASSERT_CLK(a_fail_zero_value, clk, rst_n,
        (m_tvalid && (status != pol_pkg::ST_OK)) |-> (value_out == '0),
        "failed request returned a nonzero value")
    `ASSERT_CLK(a_len_tracks_count, clk, rst_n,
        $rose(m_tvalid) |-> (length == pol_pkg::LEN_W'(stat.count)),
        "result length differs from list length")

endmodule

/* bench/positional_ordered_list_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_ordered_list_core_tb
// Streams insert, read, delete and clear requests into the list core and
// checks every result beat against a behavioral copy of the list kept in
// the bench. Covers empty and full lists, bad positions, the first and last
// entries, and random traffic with idle gaps and backpressure.
// ----------------------------------------------------------------------------
module positional_ordered_list_core_tb;

    localparam int  CLK_HALF    = 6;
    localparam int  RESET_CYC   = 12;
    localparam int  RANDOM_REQS = 1750;
    localparam int  CYCLE_LIMIT = 1000000;

    typedef struct packed {
        pol_pkg::status_t status;
        logic [31:0]      value;
        logic [5:0]       length;
    } list_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [pol_pkg::IN_TW-1:0]  s_tdata;   // action, position, value_in
    logic                       m_tvalid;
    logic                       m_tready;
    logic [pol_pkg::OUT_TW-1:0] m_tdata;   // status, value_out, length

    logic [31:0]         list_cells [pol_pkg::CAPACITY];
    int                  list_len;
    list_result_t        pending_results [$];
    int                  mismatch_count;
    int                  cycle_count;
    bit                  tx_idle_on;
    bit                  rx_stall_on;

    positional_ordered_list_core i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #(CLK_HALF);
        clk = 1'b0;
        #(CLK_HALF);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
            $display("positional_ordered_list_core_tb: FAIL");
            $finish;
        end
    end

    function automatic list_result_t apply_request(pol_pkg::action_t act, logic [5:0] pos,
                                                   logic [31:0] val);
        list_result_t res;
        int           p;
        p          = int'(pos);
        res.status = pol_pkg::ST_OK;
        res.value  = '0;
        case (act)
            pol_pkg::ACT_INSERT:
            begin
                if (p < 1 || p > list_len + 1)
                    res.status = pol_pkg::ST_BAD_POS;
                else if (list_len >= pol_pkg::CAPACITY)
                    res.status = pol_pkg::ST_FULL;
                else
                begin
                    for (int k = list_len; k >= p; k--)
                        list_cells[k] = list_cells[k-1];
                    list_cells[p-1] = val;
                    list_len++;
                end
            end
            pol_pkg::ACT_READ:
            begin
                if (p < 1 || p > list_len)
                    res.status = pol_pkg::ST_BAD_POS;
                else
                    res.value = list_cells[p-1];
            end
            pol_pkg::ACT_DELETE:
            begin
                if (p < 1 || p > list_len)
                    res.status = pol_pkg::ST_BAD_POS;
                else
                begin
                    res.value = list_cells[p-1];
                    for (int k = p; k < list_len; k++)
                        list_cells[k-1] = list_cells[k];
                    list_len--;
                end
            end
            default:
                list_len = 0;
        endcase
        res.length = 6'(list_len);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!tx_idle_on || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // mostly in range for the action, sometimes anywhere in the 6-bit field
    function automatic logic [5:0] pick_position(pol_pkg::action_t act);
        int hi;
        int r;
        hi = (act == pol_pkg::ACT_INSERT) ? list_len + 1 : list_len;
        r  = $urandom_range(0, 99);
        if (r < 85 && hi >= 1)
            return 6'($urandom_range(1, hi));
        else if (r < 90)
            return 6'(hi + 1);
        else if (r < 94)
            return 6'd0;
        else
            return 6'($urandom_range(0, 63));
    endfunction

    task automatic send_request(pol_pkg::action_t act, logic [5:0] pos, logic [31:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {val, pos, act};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(apply_request(act, pos, val));
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        list_result_t want;
        list_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = pol_pkg::status_t'(m_tdata[1:0]);
            got.value  = m_tdata[33:2];
            got.length = m_tdata[39:34];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat status %0d value %h length %0d",
                         $time, got.status, got.value, got.length);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    $display({"%0t: mismatch expected status %0d value %h length %0d,",
                              " got status %0d value %h length %0d"},
                             $time, want.status, want.value, want.length,
                             got.status, got.value, got.length);
                    mismatch_count++;
                end
            end
        end
    end

    // result side backpressure
    initial
    begin
        int hold;
        int r;
        hold     = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!rx_stall_on)
            begin
                m_tready <= 1'b1;
                hold = 0;
            end
            else if (hold > 0)
                hold--;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    m_tready <= 1'b1;
                    hold = $urandom_range(0, 7);
                end
                else if (r < 92)
                begin
                    m_tready <= 1'b0;
                    hold = $urandom_range(0, 2);
                end
                else
                begin
                    m_tready <= 1'b0;
                    hold = $urandom_range(9, 39);
                end
            end
        end
    end

    task automatic test_directed();
        send_request(pol_pkg::ACT_READ,   6'd1,  32'h1234_5678);
        send_request(pol_pkg::ACT_DELETE, 6'd1,  32'h0);
        send_request(pol_pkg::ACT_DELETE, 6'd0,  32'h0);
        send_request(pol_pkg::ACT_INSERT, 6'd0,  32'hdead_beef);
        send_request(pol_pkg::ACT_INSERT, 6'd2,  32'hdead_beef);
        send_request(pol_pkg::ACT_CLEAR,  6'd0,  32'hffff_ffff);
        send_request(pol_pkg::ACT_INSERT, 6'd1,  32'h8000_0000);
        send_request(pol_pkg::ACT_INSERT, 6'd1,  32'h7fff_ffff);
        send_request(pol_pkg::ACT_INSERT, 6'd3,  32'hffff_ffff);
        send_request(pol_pkg::ACT_INSERT, 6'd2,  32'h0000_0000);
        send_request(pol_pkg::ACT_READ,   6'd1,  32'h0);
        send_request(pol_pkg::ACT_READ,   6'd4,  32'h0);
        send_request(pol_pkg::ACT_READ,   6'd0,  32'h0);
        send_request(pol_pkg::ACT_READ,   6'd5,  32'h0);
        send_request(pol_pkg::ACT_READ,   6'd63, 32'hffff_ffff);
        send_request(pol_pkg::ACT_INSERT, 6'd63, 32'h5555_aaaa);
        send_request(pol_pkg::ACT_DELETE, 6'd63, 32'h0);
        send_request(pol_pkg::ACT_DELETE, 6'd1,  32'h0);
        send_request(pol_pkg::ACT_DELETE, 6'd3,  32'h0);
        send_request(pol_pkg::ACT_READ,   6'd2,  32'h0);
        send_request(pol_pkg::ACT_CLEAR,  6'd0,  32'h0);
        send_request(pol_pkg::ACT_READ,   6'd1,  32'h0);
        send_request(pol_pkg::ACT_DELETE, 6'd1,  32'h0);
    endtask

    task automatic test_full_list();
        send_request(pol_pkg::ACT_CLEAR, 6'd0, 32'h0);
        while (list_len < pol_pkg::CAPACITY)
            send_request(pol_pkg::ACT_INSERT, 6'($urandom_range(1, list_len + 1)),
                         pick_value());
        send_request(pol_pkg::ACT_INSERT, 6'(pol_pkg::CAPACITY + 1), 32'h1111_1111);
        send_request(pol_pkg::ACT_INSERT, 6'd1,                      32'h2222_2222);
        send_request(pol_pkg::ACT_INSERT, 6'(pol_pkg::CAPACITY + 2), 32'h3333_3333);
        send_request(pol_pkg::ACT_INSERT, 6'd0,                      32'h4444_4444);
        send_request(pol_pkg::ACT_INSERT, 6'd63,                     32'h5555_5555);
        send_request(pol_pkg::ACT_READ,   6'(pol_pkg::CAPACITY),     32'h0);
        send_request(pol_pkg::ACT_READ,   6'(pol_pkg::CAPACITY + 1), 32'h0);
        send_request(pol_pkg::ACT_DELETE, 6'(pol_pkg::CAPACITY),     32'h0);
        send_request(pol_pkg::ACT_INSERT, 6'(pol_pkg::CAPACITY),     32'h7fff_ffff);
        send_request(pol_pkg::ACT_DELETE, 6'd1,                      32'h0);
        while (list_len > 0)
            send_request(pol_pkg::ACT_DELETE, 6'($urandom_range(1, list_len)), 32'h0);
        send_request(pol_pkg::ACT_DELETE, 6'd1, 32'h0);
    endtask

    task automatic test_random_traffic(int n_reqs);
        bit               growing;
        int               r;
        pol_pkg::action_t act;
        growing = 1'b1;
        for (int i = 0; i < n_reqs; i++)
        begin
            if (i % 150 == 0)
            begin
                tx_idle_on  = ($urandom_range(0, 9) < 7);
                rx_stall_on = ($urandom_range(0, 9) < 7);
            end
            if (list_len >= pol_pkg::CAPACITY)
                growing = 1'b0;
            else if (list_len == 0)
                growing = 1'b1;
            else if ($urandom_range(0, 39) == 0)
                growing = !growing;
            r = $urandom_range(0, 99);
            if (r < 1)
                act = pol_pkg::ACT_CLEAR;
            else if (r < (growing ? 55 : 25))
                act = pol_pkg::ACT_INSERT;
            else if (r < 62)
                act = pol_pkg::ACT_READ;
            else
                act = pol_pkg::ACT_DELETE;
            send_request(act, pick_position(act), pick_value());
        end
    endtask

    task automatic test_drain_pause();
        for (int n = 0; n < 4; n++)
        begin
            test_random_traffic(20);
            stop_sending();
            wait_results_drained();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        list_len       = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        tx_idle_on     = 1'b1;
        rx_stall_on    = 1'b1;
        repeat (RESET_CYC) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_full_list();
        test_drain_pause();
        test_random_traffic(RANDOM_REQS);

        stop_sending();
        wait_results_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("positional_ordered_list_core_tb: PASS");
        else
            $display("positional_ordered_list_core_tb: FAIL");
        $finish;
    end

endmodule
